>>> hw/rtl/lobm_pkg.sv
package lobm_pkg;

    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_CANCEL = 1'b1;

    // Widest level and id that any parameter setting can ask for
    localparam int CMD_ID_W  = 16;
    localparam int CMD_LVL_W = 12;
    localparam int QTY_W     = 32;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 112;

    typedef enum logic [2:0] {
        ST_RESTED    = 3'd0,
        ST_FILLED    = 3'd1,
        ST_BAD_PRICE = 3'd2,
        ST_BAD_ID    = 3'd3,
        ST_CANCELLED = 3'd4,
        ST_NOT_FOUND = 3'd5
    } t_status;

    // What the front end decided about an item before the book is touched
    typedef enum logic [2:0] {
        K_SUBMIT,
        K_CANCEL,
        K_REJ_PRICE,
        K_REJ_ID,
        K_CAN_NF
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [CMD_ID_W-1:0]    id;
        logic                   sell;
        logic [CMD_LVL_W-1:0]   lvl;
        logic [QTY_W-1:0]       qty;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

    typedef struct packed {
        logic ready;
        logic pop;
    } t_bctl;

    // First member is the top bits: status lands in bit 0 upward
    typedef struct packed {
        logic [31:0] total;
        logic [10:0] resting;
        logic [7:0]  ask;
        logic [8:0]  bid;
        logic [31:0] remain;
        logic [10:0] fills;
        t_status     status;
    } t_result;

endpackage

>>> hw/rtl/limit_order_book_matcher.sv
// Price-time priority limit order book.
// Input stream: s_axis_tuser is the opcode (submit or cancel); s_axis_tdata
// carries order id, side, signed tick price and quantity. Every transfer in
// gives exactly one transfer out on m_axis, in order, with status, fill count,
// remaining quantity, both best level indices, resting count and fill total.
// Front end: checks price and id range and holds up to two classified items.
// Back end: a sequencer over order and level memories (one read and one write
// port each) walks the opposite side level by level and order by order.
// A reject goes straight to the result; a cancel unlinks the order and, when
// it empties the best level, steps the best index past empty levels; a submit
// sweeps the opposite side, filling resting orders and stepping past empty
// levels, then rests any remainder. One item at a time in the back end, and
// the next starts only once the result register is empty.
// Reset: a clearing pass writes the live flags and level heads and tails;
// s_axis_tready stays low until it ends.
// Stall: a held result sits in the output register; the front end keeps
// taking transfers until its queue fills, then drops s_axis_tready.
module limit_order_book_matcher
    import lobm_pkg::*;
#(
    parameter int TICK_SPAN     = 127,
    parameter int MAX_ORDER_IDS = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // id[15:0], side_is_sell[16], price_ticks[32:17], quantity[64:33]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode[0]
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status[2:0], fill_count[13:3], remaining_qty[45:14], best_bid_level[54:46],
    // best_ask_level[62:55], resting_orders[73:63], total_fills[105:74]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_qhead  qhead;
    t_bctl   bctl;
    t_result result;

    lobm_front #(
        .TICK_SPAN    (TICK_SPAN),
        .MAX_ORDER_IDS(MAX_ORDER_IDS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .i_bctl       (bctl),
        .o_qhead      (qhead)
    );

    lobm_engine #(
        .TICK_SPAN    (TICK_SPAN),
        .MAX_ORDER_IDS(MAX_ORDER_IDS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qhead (qhead),
        .o_bctl  (bctl),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_result(result)
    );

    // Pad the result up to whole bytes
    assign m_axis_tdata = {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, result};

endmodule

>>> hw/rtl/lobm_ram.sv
module lobm_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/lobm_front.sv
module lobm_front
    import lobm_pkg::*;
#(
    parameter int TICK_SPAN     = 127,
    parameter int MAX_ORDER_IDS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  t_bctl                 i_bctl,
    output t_qhead                o_qhead
);

    localparam int TOTAL = 2 * TICK_SPAN + 1;

    logic [15:0]        in_id;
    logic               in_sell;
    logic signed [15:0] in_price;
    logic [31:0]        in_qty;
    logic signed [17:0] lvl_s;
    logic               price_bad;
    logic               id_bad;
    t_cmd               cmd;
    logic               push;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign in_id    = s_axis_tdata[15:0];
    assign in_sell  = s_axis_tdata[16];
    assign in_price = s_axis_tdata[32:17];
    assign in_qty   = s_axis_tdata[64:33];

    assign lvl_s     = 18'(in_price) + signed'(18'(TICK_SPAN));
    assign price_bad = (lvl_s < 0) || (lvl_s >= signed'(18'(TOTAL)));
    assign id_bad    = 17'(in_id) >= 17'(MAX_ORDER_IDS);

    // Classify: range checks are settled here, liveness in the back end
    always_comb begin
        cmd.id   = in_id;
        cmd.sell = in_sell;
        cmd.lvl  = lvl_s[CMD_LVL_W-1:0];
        cmd.qty  = in_qty;
        if (s_axis_tuser == OP_SUBMIT) begin
            if (price_bad) begin
                cmd.kind = K_REJ_PRICE;
            end else if (id_bad) begin
                cmd.kind = K_REJ_ID;
            end else begin
                cmd.kind = K_SUBMIT;
            end
        end else begin
            cmd.kind = id_bad ? K_CAN_NF : K_CANCEL;
        end
    end

    assign s_axis_tready = i_bctl.ready && (r_cnt != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= cmd;
                r_wp      <= ~r_wp;
            end
            if (i_bctl.pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_bctl.pop);
        end
    end

    assign o_qhead.valid = (r_cnt != 2'd0);
    assign o_qhead.cmd   = r_q[r_rp];

endmodule

>>> hw/rtl/lobm_engine.sv
module lobm_engine
    import lobm_pkg::*;
#(
    parameter int TICK_SPAN     = 127,
    parameter int MAX_ORDER_IDS = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_qhead  i_qhead,
    output t_bctl   o_bctl,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam int TOTAL     = 2 * TICK_SPAN + 1;
    localparam int LVL_W     = $clog2(TOTAL + 1);
    localparam int BW        = LVL_W + 1;
    localparam int NSLOT     = 2 * TOTAL;
    localparam int SLOT_W    = $clog2(NSLOT);
    localparam int ID_W      = $clog2(MAX_ORDER_IDS);
    localparam int LINK_W    = ID_W + 1;
    localparam int CLR_DEPTH = (MAX_ORDER_IDS > NSLOT) ? MAX_ORDER_IDS : NSLOT;
    localparam int CLR_W     = $clog2(CLR_DEPTH + 1);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_ORDER_IDS);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RDID, S_SWCK, S_HDRD, S_HDCK, S_DRRD, S_DRCK,
        S_SCAN, S_SCCK, S_APRD, S_APCK, S_APLN, S_DONE
    } t_state;

    function automatic logic [SLOT_W-1:0] slot_of(input logic sell,
                                                 input logic [LVL_W-1:0] lvl);
        slot_of = (sell ? SLOT_W'(TOTAL) : SLOT_W'(0)) + SLOT_W'(lvl);
    endfunction

    t_state              r_state;
    t_cmd                r_cmd;
    logic [31:0]         r_q;
    logic [LINK_W-1:0]   r_fills;
    t_status             r_status;
    logic [LINK_W-1:0]   r_cur;
    logic [SLOT_W-1:0]   r_slot;
    logic [LINK_W-1:0]   r_tail;
    logic signed [BW-1:0] r_bid;
    logic [LVL_W-1:0]    r_ask;
    logic [LINK_W-1:0]   r_resting;
    logic [31:0]         r_total;
    logic [CLR_W-1:0]    r_clr;
    logic                r_scan_ask;
    t_result             r_out;
    logic                r_out_valid;

    // Memory ports
    logic                 live_we, rem_we, meta_we, nxt_we, prv_we, head_we, tail_we;
    logic [ID_W-1:0]      live_wa, rem_wa, meta_wa, nxt_wa, prv_wa;
    logic [ID_W-1:0]      live_ra, rem_ra, meta_ra, nxt_ra, prv_ra;
    logic [SLOT_W-1:0]    head_wa, tail_wa, head_ra, tail_ra;
    logic                 live_wd, rd_live;
    logic [31:0]          rem_wd, rd_rem;
    logic [LVL_W:0]       meta_wd, rd_meta;
    logic [LINK_W-1:0]    nxt_wd, prv_wd, head_wd, tail_wd;
    logic [LINK_W-1:0]    rd_nxt, rd_prv, rd_head, rd_tail;

    logic                 start;
    logic                 meta_sell;
    logic [LVL_W-1:0]     meta_lvl;
    logic [SLOT_W-1:0]    can_slot;
    logic                 p_null, n_null, full;
    logic [LVL_W-1:0]     lim;
    logic                 sweep_go;
    logic [LVL_W-1:0]     nb_ask;
    logic signed [BW-1:0] nb_bid;
    logic [ID_W-1:0]      cmd_idx, cur_idx, q_idx;
    logic [LINK_W-1:0]    cmd_link;
    t_state               scan_ret;

    assign start     = (r_state == S_IDLE) && i_qhead.valid && !r_out_valid;
    assign meta_sell = rd_meta[LVL_W];
    assign meta_lvl  = rd_meta[LVL_W-1:0];
    assign can_slot  = slot_of(meta_sell, meta_lvl);
    assign p_null    = (rd_prv == NULL_LINK);
    assign n_null    = (rd_nxt == NULL_LINK);
    assign full      = (rd_rem <= r_q);
    assign lim       = r_cmd.lvl[LVL_W-1:0];
    assign nb_ask    = r_ask + LVL_W'(1);
    assign nb_bid    = r_bid - BW'(1);
    assign cmd_idx   = r_cmd.id[ID_W-1:0];
    assign cmd_link  = LINK_W'(cmd_idx);
    assign cur_idx   = r_cur[ID_W-1:0];
    assign q_idx     = i_qhead.cmd.id[ID_W-1:0];
    assign scan_ret  = (r_cmd.kind == K_CANCEL) ? S_DONE : S_SWCK;

    always_comb begin
        if (!r_cmd.sell) begin
            sweep_go = (r_ask <= lim) && (r_ask < LVL_W'(TOTAL)) && (r_q != 32'd0);
        end else begin
            sweep_go = (r_bid >= $signed({1'b0, lim})) && (r_bid >= 0) && (r_q != 32'd0);
        end
    end

    // Read addresses
    always_comb begin
        live_ra = q_idx;
        meta_ra = q_idx;
        prv_ra  = q_idx;
        rem_ra  = (r_state == S_DRRD) ? cur_idx : q_idx;
        nxt_ra  = (r_state == S_DRRD) ? cur_idx : q_idx;
        tail_ra = r_slot;
        if (r_state == S_SCAN) begin
            head_ra = r_scan_ask ? slot_of(1'b1, nb_ask) : slot_of(1'b0, nb_bid[LVL_W-1:0]);
        end else begin
            head_ra = r_slot;
        end
    end

    // Write ports
    always_comb begin
        live_we = 1'b0; live_wa = cmd_idx; live_wd = 1'b0;
        rem_we  = 1'b0; rem_wa  = cmd_idx; rem_wd  = r_q;
        meta_we = 1'b0; meta_wa = cmd_idx; meta_wd = {r_cmd.sell, lim};
        nxt_we  = 1'b0; nxt_wa  = cmd_idx; nxt_wd  = NULL_LINK;
        prv_we  = 1'b0; prv_wa  = cmd_idx; prv_wd  = NULL_LINK;
        head_we = 1'b0; head_wa = r_slot;  head_wd = NULL_LINK;
        tail_we = 1'b0; tail_wa = r_slot;  tail_wd = NULL_LINK;
        case (r_state)
            S_CLR: begin
                live_we = (r_clr < CLR_W'(MAX_ORDER_IDS));
                live_wa = r_clr[ID_W-1:0];
                head_we = (r_clr < CLR_W'(NSLOT));
                head_wa = r_clr[SLOT_W-1:0];
                tail_we = head_we;
                tail_wa = r_clr[SLOT_W-1:0];
            end
            S_RDID: begin
                if (r_cmd.kind == K_CANCEL && rd_live) begin
                    live_we = 1'b1;
                    if (!p_null) begin
                        nxt_we = 1'b1; nxt_wa = rd_prv[ID_W-1:0]; nxt_wd = rd_nxt;
                    end else begin
                        head_we = 1'b1; head_wa = can_slot; head_wd = rd_nxt;
                    end
                    if (!n_null) begin
                        prv_we = 1'b1; prv_wa = rd_nxt[ID_W-1:0]; prv_wd = rd_prv;
                    end else begin
                        tail_we = 1'b1; tail_wa = can_slot; tail_wd = rd_prv;
                    end
                end
            end
            S_DRCK: begin
                if (full) begin
                    head_we = 1'b1; head_wd = rd_nxt;
                    live_we = 1'b1; live_wa = cur_idx;
                    if (!n_null) begin
                        prv_we = 1'b1; prv_wa = rd_nxt[ID_W-1:0];
                    end else begin
                        tail_we = 1'b1;
                    end
                end else begin
                    rem_we = 1'b1; rem_wa = cur_idx; rem_wd = rd_rem - r_q;
                end
            end
            S_APCK: begin
                tail_we = 1'b1; tail_wd = cmd_link;
                if (rd_tail == NULL_LINK) begin
                    head_we = 1'b1; head_wd = cmd_link;
                end
                rem_we  = 1'b1;
                meta_we = 1'b1;
                live_we = 1'b1; live_wd = 1'b1;
                prv_we  = 1'b1; prv_wd = rd_tail;
                nxt_we  = 1'b1;
            end
            S_APLN: begin
                nxt_we = 1'b1; nxt_wa = r_tail[ID_W-1:0]; nxt_wd = cmd_link;
            end
            default: begin
            end
        endcase
    end

    lobm_ram #(.W(1), .DEPTH(MAX_ORDER_IDS)) u_live (
        .i_clk(i_clk), .i_we(live_we), .i_waddr(live_wa), .i_wdata(live_wd),
        .i_raddr(live_ra), .o_rdata(rd_live));
    lobm_ram #(.W(32), .DEPTH(MAX_ORDER_IDS)) u_rem (
        .i_clk(i_clk), .i_we(rem_we), .i_waddr(rem_wa), .i_wdata(rem_wd),
        .i_raddr(rem_ra), .o_rdata(rd_rem));
    lobm_ram #(.W(LVL_W + 1), .DEPTH(MAX_ORDER_IDS)) u_meta (
        .i_clk(i_clk), .i_we(meta_we), .i_waddr(meta_wa), .i_wdata(meta_wd),
        .i_raddr(meta_ra), .o_rdata(rd_meta));
    lobm_ram #(.W(LINK_W), .DEPTH(MAX_ORDER_IDS)) u_nxt (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(nxt_wd),
        .i_raddr(nxt_ra), .o_rdata(rd_nxt));
    lobm_ram #(.W(LINK_W), .DEPTH(MAX_ORDER_IDS)) u_prv (
        .i_clk(i_clk), .i_we(prv_we), .i_waddr(prv_wa), .i_wdata(prv_wd),
        .i_raddr(prv_ra), .o_rdata(rd_prv));
    lobm_ram #(.W(LINK_W), .DEPTH(NSLOT)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_wa), .i_wdata(head_wd),
        .i_raddr(head_ra), .o_rdata(rd_head));
    lobm_ram #(.W(LINK_W), .DEPTH(NSLOT)) u_tail (
        .i_clk(i_clk), .i_we(tail_we), .i_waddr(tail_wa), .i_wdata(tail_wd),
        .i_raddr(tail_ra), .o_rdata(rd_tail));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_bid       <= -BW'(1);
            r_ask       <= LVL_W'(TOTAL);
            r_resting   <= '0;
            r_total     <= '0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + CLR_W'(1);
                    if (r_clr == CLR_W'(CLR_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_cmd   <= i_qhead.cmd;
                        r_q     <= i_qhead.cmd.qty;
                        r_fills <= '0;
                        case (i_qhead.cmd.kind)
                            K_REJ_PRICE: begin
                                r_status <= ST_BAD_PRICE;
                                r_state  <= S_DONE;
                            end
                            K_REJ_ID: begin
                                r_status <= ST_BAD_ID;
                                r_state  <= S_DONE;
                            end
                            K_CAN_NF: begin
                                r_status <= ST_NOT_FOUND;
                                r_q      <= '0;
                                r_state  <= S_DONE;
                            end
                            default: r_state <= S_RDID;
                        endcase
                    end
                end
                S_RDID: begin
                    if (r_cmd.kind == K_CANCEL) begin
                        if (!rd_live) begin
                            r_status <= ST_NOT_FOUND;
                            r_q      <= '0;
                            r_state  <= S_DONE;
                        end else begin
                            r_status   <= ST_CANCELLED;
                            r_q        <= rd_rem;
                            r_resting  <= r_resting - LINK_W'(1);
                            r_scan_ask <= meta_sell;
                            if (p_null && n_null &&
                                (meta_sell ? (meta_lvl == r_ask)
                                           : ($signed({1'b0, meta_lvl}) == r_bid))) begin
                                r_state <= S_SCAN;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                    end else if (rd_live) begin
                        r_status <= ST_BAD_ID;
                        r_state  <= S_DONE;
                    end else begin
                        r_scan_ask <= !r_cmd.sell;
                        r_state    <= S_SWCK;
                    end
                end
                S_SWCK: begin
                    if (sweep_go) begin
                        r_slot  <= r_cmd.sell ? slot_of(1'b0, r_bid[LVL_W-1:0])
                                              : slot_of(1'b1, r_ask);
                        r_state <= S_HDRD;
                    end else if (r_q != 32'd0) begin
                        r_slot  <= slot_of(r_cmd.sell, lim);
                        r_state <= S_APRD;
                    end else begin
                        r_status <= ST_FILLED;
                        r_state  <= S_DONE;
                    end
                end
                S_HDRD: r_state <= S_HDCK;
                S_HDCK: begin
                    r_cur   <= rd_head;
                    r_state <= (rd_head == NULL_LINK) ? S_SCAN : S_DRRD;
                end
                S_DRRD: r_state <= S_DRCK;
                S_DRCK: begin
                    r_fills <= r_fills + LINK_W'(1);
                    if (full) begin
                        r_q       <= r_q - rd_rem;
                        r_resting <= r_resting - LINK_W'(1);
                        if (n_null) begin
                            r_state <= S_SCAN;
                        end else if (r_q == rd_rem) begin
                            r_state <= S_SWCK;
                        end else begin
                            r_cur   <= rd_nxt;
                            r_state <= S_DRRD;
                        end
                    end else begin
                        r_q     <= '0;
                        r_state <= S_SWCK;
                    end
                end
                S_SCAN: begin
                    // step the best index past one empty level
                    if (r_scan_ask) begin
                        r_ask   <= nb_ask;
                        r_state <= (nb_ask == LVL_W'(TOTAL)) ? scan_ret : S_SCCK;
                    end else begin
                        r_bid   <= nb_bid;
                        r_state <= (nb_bid < 0) ? scan_ret : S_SCCK;
                    end
                end
                S_SCCK: r_state <= (rd_head == NULL_LINK) ? S_SCAN : scan_ret;
                S_APRD: r_state <= S_APCK;
                S_APCK: begin
                    r_tail    <= rd_tail;
                    r_resting <= r_resting + LINK_W'(1);
                    r_status  <= ST_RESTED;
                    if (!r_cmd.sell && ($signed({1'b0, lim}) > r_bid)) begin
                        r_bid <= $signed({1'b0, lim});
                    end
                    if (r_cmd.sell && (lim < r_ask)) begin
                        r_ask <= lim;
                    end
                    r_state <= (rd_tail != NULL_LINK) ? S_APLN : S_DONE;
                end
                S_APLN: r_state <= S_DONE;
                S_DONE: begin
                    if (r_status == ST_RESTED || r_status == ST_FILLED) begin
                        r_total       <= r_total + 32'(r_fills);
                        r_out.total   <= r_total + 32'(r_fills);
                    end else begin
                        r_out.total   <= r_total;
                    end
                    r_out.status  <= r_status;
                    r_out.fills   <= 11'(r_fills);
                    r_out.remain  <= r_q;
                    r_out.bid     <= 9'(r_bid);
                    r_out.ask     <= 8'(r_ask);
                    r_out.resting <= 11'(r_resting);
                    r_out_valid   <= 1'b1;
                    r_state       <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_bctl.ready = (r_state != S_CLR);
    assign o_bctl.pop   = start;
    assign o_valid      = r_out_valid;
    assign o_result     = r_out;

endmodule

>>> hw/rtl/lobm_checker.sv
module lobm_checker
    import lobm_pkg::*;
#(
    parameter int TICK_SPAN = 127
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int TOTAL = 2 * TICK_SPAN + 1;

    // hold a result until it is taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a rested order leaves something open
    a_rested: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] == ST_RESTED) |-> (m_axis_tdata[45:14] != 32'd0))
        else $error("rested with nothing left");

    // a full fill leaves nothing open
    a_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] == ST_FILLED) |-> (m_axis_tdata[45:14] == 32'd0))
        else $error("filled with quantity left");

    // an empty book shows both best indices at their sentinels
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[73:63] == 11'd0) |->
            (m_axis_tdata[54:46] == 9'h1FF) && (m_axis_tdata[62:55] == 8'(TOTAL)))
        else $error("best index stale on empty book");

endmodule

bind limit_order_book_matcher lobm_checker #(
    .TICK_SPAN(TICK_SPAN)
) u_lobm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

>>> tb/sv/tb_top.sv
module tb_top;
    import lobm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICKS    = 127;
    localparam int IDS      = 1024;
    localparam int LEVELS   = 2 * TICKS + 1;
    localparam int NULL_REF = IDS;
    localparam int CYCLE_LIMIT = 2000000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // id, side_is_sell, price_ticks, quantity (lowest first)
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // opcode
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // status, fill_count, remaining_qty, best_bid, best_ask, resting, total_fills
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    limit_order_book_matcher #(.TICK_SPAN(TICKS), .MAX_ORDER_IDS(IDS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // Shadow book
    bit          bk_live [IDS];
    logic [31:0] bk_rem  [IDS];
    bit          bk_sell [IDS];
    int          bk_lvl  [IDS];
    int          bk_next [IDS];
    int          bk_prev [IDS];
    int          lv_head [2*LEVELS];
    int          lv_tail [2*LEVELS];
    int          best_bid, best_ask;
    int          resting;
    logic [31:0] fill_total;

    logic [OUT_TDATA_W-1:0] expected_results[$];
    int  mismatches;
    bit  quiet;          // no idling in the final part
    bit  hold_off_req;
    int  cycles;

    function automatic int slot(bit sell, int lvl);
        return (sell ? LEVELS : 0) + lvl;
    endfunction

    function automatic void book_clear();
        for (int i = 0; i < IDS; i++) begin
            bk_live[i] = 0; bk_rem[i] = 0; bk_next[i] = NULL_REF; bk_prev[i] = NULL_REF;
        end
        for (int i = 0; i < 2*LEVELS; i++) begin
            lv_head[i] = NULL_REF; lv_tail[i] = NULL_REF;
        end
        best_bid = -1; best_ask = LEVELS; resting = 0; fill_total = 0;
    endfunction

    function automatic void book_unlink(int s, int id);
        int p, n;
        p = bk_prev[id]; n = bk_next[id];
        if (p != NULL_REF) bk_next[p] = n; else lv_head[s] = n;
        if (n != NULL_REF) bk_prev[n] = p; else lv_tail[s] = p;
    endfunction

    function automatic void skip_empty(bit sell);
        if (sell) begin
            while (best_ask < LEVELS && lv_head[slot(1, best_ask)] == NULL_REF) best_ask++;
        end else begin
            while (best_bid >= 0 && lv_head[slot(0, best_bid)] == NULL_REF) best_bid--;
        end
    endfunction

    // Work out the single result caused by one order command
    function automatic logic [OUT_TDATA_W-1:0] match_order(bit op, logic [15:0] id,
            bit sell, logic signed [15:0] px, logic [31:0] qty);
        t_status st;
        int fills, lvl, s, r;
        logic [31:0] left, m;
        t_result res;
        fills = 0; left = 0;
        if (op == OP_SUBMIT) begin
            lvl = int'(px) + TICKS;
            left = qty;
            if (lvl < 0 || lvl >= LEVELS) st = ST_BAD_PRICE;
            else if (id >= IDS || bk_live[id]) st = ST_BAD_ID;
            else begin
                // sweep the opposite side from its best level
                forever begin
                    if (left == 0) break;
                    if (!sell) begin
                        if (!(best_ask <= lvl && best_ask < LEVELS)) break;
                        s = slot(1, best_ask);
                    end else begin
                        if (!(best_bid >= lvl && best_bid >= 0)) break;
                        s = slot(0, best_bid);
                    end
                    while (lv_head[s] != NULL_REF && left > 0) begin
                        r = lv_head[s];
                        m = bk_rem[r] < left ? bk_rem[r] : left;
                        bk_rem[r] -= m; left -= m; fills++;
                        if (bk_rem[r] == 0) begin
                            book_unlink(s, r); bk_live[r] = 0; resting--;
                        end
                    end
                    if (lv_head[s] == NULL_REF) skip_empty(!sell);
                end
                fill_total += fills;
                if (left > 0) begin
                    s = slot(sell, lvl);
                    bk_rem[id] = left; bk_sell[id] = sell; bk_lvl[id] = lvl;
                    bk_next[id] = NULL_REF; bk_prev[id] = lv_tail[s];
                    if (lv_tail[s] != NULL_REF) bk_next[lv_tail[s]] = id;
                    else lv_head[s] = id;
                    lv_tail[s] = id;
                    bk_live[id] = 1; resting++;
                    if (!sell && lvl > best_bid) best_bid = lvl;
                    if (sell && lvl < best_ask) best_ask = lvl;
                    st = ST_RESTED;
                end else st = ST_FILLED;
            end
        end else begin
            if (id >= IDS || !bk_live[id]) st = ST_NOT_FOUND;
            else begin
                s = slot(bk_sell[id], bk_lvl[id]);
                left = bk_rem[id];
                book_unlink(s, id); bk_live[id] = 0; resting--;
                if (lv_head[s] == NULL_REF) begin
                    if (!bk_sell[id] && bk_lvl[id] == best_bid) skip_empty(0);
                    if (bk_sell[id] && bk_lvl[id] == best_ask) skip_empty(1);
                end
                st = ST_CANCELLED;
            end
        end
        res.status  = st;
        res.fills   = 11'(fills);
        res.remain  = left;
        res.bid     = 9'(best_bid);
        res.ask     = 8'(best_ask);
        res.resting = 11'(resting);
        res.total   = fill_total;
        return OUT_TDATA_W'(res);
    endfunction

    // Offer one command and hold it until the transfer; the next call or
    // drain_wait decides what the input shows afterwards
    task automatic send_order(bit op, logic [15:0] id, bit sell,
            logic [15:0] px, logic [31:0] qty);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_TDATA_W'({qty, px, sell, id});
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(match_order(op, id, sell, px, qty));
    endtask

    task automatic drain_wait();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        logic [OUT_TDATA_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[105:0] !== want[105:0]) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch: exp st=%0d f=%0d rem=%0d bid=%0d %s",
                            want[2:0], want[13:3], want[45:14], $signed(want[54:46]),
                            $sformatf("ask=%0d rest=%0d tot=%0d", want[62:55],
                                      want[73:63], want[105:74]));
                        $display("                 got st=%0d f=%0d rem=%0d bid=%0d %s",
                            m_axis_tdata[2:0], m_axis_tdata[13:3], m_axis_tdata[45:14],
                            $signed(m_axis_tdata[54:46]),
                            $sformatf("ask=%0d rest=%0d tot=%0d", m_axis_tdata[62:55],
                                      m_axis_tdata[73:63], m_axis_tdata[105:74]));
                    end
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int n;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                for (n = 0; n < 400; n++) @(posedge i_clk);
                hold_off_req = 0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("limit_order_book_matcher regression: fail");
            $finish;
        end
    end

    function automatic logic [15:0] pick_px();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'($urandom);
        // cluster round the reference so that orders cross
        return 16'($signed($urandom_range(0, 20)) - 10);
    endfunction

    // Extremes of every field and each special case
    task automatic test_directed();
        send_order(OP_CANCEL, 16'd5, 0, 0, 0);                 // cancel on empty book
        send_order(OP_SUBMIT, 16'd1, 0, 16'sd128, 32'd10);     // price just too high
        send_order(OP_SUBMIT, 16'd1, 1, -16'sd128, 32'd10);    // price just too low
        send_order(OP_SUBMIT, 16'hFFFF, 1, 16'h8000, 32'hFFFFFFFF);
        send_order(OP_SUBMIT, 16'hFFFF, 0, 16'sd0, 32'd5);     // id out of range
        send_order(OP_SUBMIT, 16'd1023, 0, -16'sd127, 32'hFFFFFFFF); // lowest bid
        send_order(OP_SUBMIT, 16'd0, 1, 16'sd127, 32'hFFFFFFFF);     // highest ask
        send_order(OP_SUBMIT, 16'd0, 1, 16'sd3, 32'd7);        // id already resting
        send_order(OP_SUBMIT, 16'd7, 0, 16'sd0, 32'd0);        // zero quantity
        send_order(OP_SUBMIT, 16'd2, 0, 16'sd1, 32'd100);
        send_order(OP_SUBMIT, 16'd3, 0, 16'sd1, 32'd50);
        send_order(OP_SUBMIT, 16'd4, 1, 16'sd0, 32'd120);      // sweeps fifo partly
        send_order(OP_SUBMIT, 16'd5, 1, -16'sd127, 32'd40);    // walks down to the low bid
        send_order(OP_CANCEL, 16'd1023, 1, 16'h7FFF, 32'hFFFFFFFF);
        send_order(OP_CANCEL, 16'd0, 0, 0, 0);
        send_order(OP_CANCEL, 16'hFFFF, 0, 0, 0);
        send_order(OP_SUBMIT, 16'd6, 0, 16'sd127, 32'hFFFFFFFF); // rests on an empty book
        send_order(OP_CANCEL, 16'd6, 0, 0, 0);
        drain_wait();
    endtask

    task automatic test_random(int count);
        int r;
        logic [15:0] id;
        logic [31:0] qty;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            id = (r < 3) ? 16'($urandom) : 16'($urandom_range(0, 63));
            if (r < 2) id = 16'($urandom_range(IDS - 8, IDS - 1));
            qty = ($urandom_range(0, 15) == 0) ? $urandom : 32'($urandom_range(1, 300));
            if (r < 70) send_order(OP_SUBMIT, id, 1'($urandom), pick_px(), qty);
            else send_order(OP_CANCEL, id, 1'($urandom), 16'($urandom), $urandom);
        end
    endtask

    // Keep the sender offering while the receiver holds off for long
    task automatic test_backpressure();
        hold_off_req = 1;
        test_random(40);
        drain_wait();
    endtask

    initial begin
        mismatches = 0; cycles = 0; quiet = 0; hold_off_req = 0;
        book_clear();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = 1'b0;
        s_axis_tdata = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(1300);
        quiet = 1;
        test_random(200);
        drain_wait();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("limit_order_book_matcher regression: pass");
        end else begin
            $display("limit_order_book_matcher regression: fail");
        end
        $finish;
    end
endmodule

>>> files.f
hw/rtl/lobm_pkg.sv
hw/rtl/lobm_ram.sv
hw/rtl/lobm_front.sv
hw/rtl/lobm_engine.sv
hw/rtl/limit_order_book_matcher.sv
hw/rtl/lobm_checker.sv
tb/sv/tb_top.sv
